[hw/rtl/gwc_pkg.sv]
package gwc_pkg;

	// input item codes
	typedef enum logic [1:0] {
		KIND_COEF  = 2'd0,
		KIND_PIXEL = 2'd1,
		KIND_FLUSH = 2'd2
	} kind_t;

	localparam int KIND_W   = 2;
	localparam int COEF_W   = 16;
	localparam int OFS_W    = 3;
	localparam int SRC_W    = 16;
	localparam int RADIUS_W = 3;
	localparam int OUT_W    = 39;
	localparam int POS_W    = 7;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 3'd2;

	// result tag that follows an item down the pipeline
	typedef struct packed {
		logic             emit;
		logic             last;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} meta_t;

	// per-cycle control shared by the cell chain
	typedef struct packed {
		logic en;
		logic shift;
	} cell_ctl_t;

endpackage

[hw/rtl/gwc_ram.sv]
module gwc_ram #(
	parameter int DW    = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/gwc_cell.sv]
module gwc_cell #(
	parameter int N  = 9,
	parameter int PB = 16
) (
	input  logic                                   clk,
	input  gwc_pkg::cell_ctl_t                     ctl,
	input  logic [N-1:0][PB-1:0]                   col_in,
	input  logic [N-1:0]                           mask,
	input  logic [N-1:0][gwc_pkg::COEF_W-1:0]      weight,
	output logic [N-1:0][PB-1:0]                   col_out,
	output logic [PB+gwc_pkg::COEF_W+$clog2(N)-1:0] sum_out
);

	localparam int PROD_W = PB + gwc_pkg::COEF_W;
	localparam int SUM_W  = PROD_W + $clog2(N);

	logic [N-1:0][PB-1:0]     col_q;
	logic [N-1:0][PROD_W-1:0] prod_s2;
	logic [SUM_W-1:0]         sum_s3;
	logic [SUM_W-1:0]         sum_c;

	// column moves on to the next cell once per stream position
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	// one product per row of this column
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int j = 0; j < N; j++) begin
				prod_s2[j] <= mask[j] ? PROD_W'(col_in[j] * weight[j]) : '0;
			end
		end
	end

	// column sum
	always_comb begin
		sum_c = '0;
		for (int j = 0; j < N; j++) begin
			sum_c = sum_c + SUM_W'(prod_s2[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sum_s3 <= sum_c;
		end
	end

	assign col_out = col_q;
	assign sum_out = sum_s3;

endmodule

[hw/rtl/gaussian_window_convolution.sv]
// Streaming window convolution: raster pixels in, one weighted window sum out per pixel,
// taking one item per clock while in_stall is low, with no dead cycles inside or between
// frames. Each result appears radius*WIDTH + radius stream positions after its center
// pixel, so the host sends that many flush items after the last pixel of a frame. Window
// columns live in a chain of 2*MAX_RADIUS+1 cells fed by a single line-buffer RAM of WIDTH
// words; items pass stage 1, the cell product and sum registers, then the output register.
// Weights are loaded by coefficient items in stream order and apply to every later pixel.
// The output has a skid register, so the input stall only rises after two results wait.
module gaussian_window_convolution #(
	parameter int WIDTH      = 128,
	parameter int HEIGHT     = 128,
	parameter int MAX_RADIUS = 4,
	parameter int PIXEL_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [gwc_pkg::RADIUS_W-1:0]     cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [gwc_pkg::KIND_W-1:0]       kind,
	input  logic [gwc_pkg::OFS_W-1:0]        coef_col,
	input  logic [gwc_pkg::OFS_W-1:0]        coef_row,
	input  logic [gwc_pkg::COEF_W-1:0]       coef_value,
	input  logic [gwc_pkg::SRC_W-1:0]        pixel_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gwc_pkg::OUT_W-1:0]        out_value,
	output logic [gwc_pkg::POS_W-1:0]        out_col,
	output logic [gwc_pkg::POS_W-1:0]        out_row,
	output logic                             frame_last
);

	localparam int N      = 2 * MAX_RADIUS + 1;
	localparam int PB     = PIXEL_BITS;
	localparam int LB_W   = (N - 1) * PB;
	localparam int CW     = $clog2(WIDTH);
	localparam int RW     = $clog2(HEIGHT + MAX_RADIUS + 1);
	localparam int SC     = CW + 3;
	localparam int SR     = RW + 3;
	localparam int SIDE   = MAX_RADIUS + 1;
	localparam int CI_W   = $clog2(SIDE * SIDE);
	localparam int SUM_W  = PB + gwc_pkg::COEF_W + $clog2(N);
	localparam int TOT_W  = SUM_W + $clog2(N);

	logic                                 en;
	logic                                 in_accept;
	logic                                 pos_item;
	logic [gwc_pkg::RADIUS_W-1:0]         radius_q;
	logic [gwc_pkg::RADIUS_W-1:0]         r_eff;
	logic [CW-1:0]                        p_col_q;
	logic [RW-1:0]                        p_row_q;
	logic signed [SC-1:0]                 qc;
	logic signed [SR-1:0]                 qr;
	logic                                 emit_c;
	logic                                 last_c;
	logic                                 wrap_c;
	logic [N-1:0]                         cmask_c;
	logic [N-1:0]                         rmask_c;

	logic                                 s1_valid_q;
	logic                                 s1_pos;
	logic                                 s1_coef;
	logic [PB-1:0]                        s1_px;
	logic [CW-1:0]                        s1_col;
	logic [N-1:0]                         s1_cmask;
	logic [N-1:0]                         s1_rmask;
	gwc_pkg::meta_t                       s1_meta;
	logic [gwc_pkg::OFS_W-1:0]            s1_ccol;
	logic [gwc_pkg::OFS_W-1:0]            s1_crow;
	logic [gwc_pkg::COEF_W-1:0]           s1_cval;
	gwc_pkg::meta_t                       meta_s2;
	gwc_pkg::meta_t                       meta_s3;

	logic [LB_W-1:0]                      lb_rdata;
	logic [LB_W-1:0]                      lb_wdata;
	logic                                 lb_we;

	logic [SIDE*SIDE-1:0][gwc_pkg::COEF_W-1:0] coef_q;
	logic [N-1:0][N-1:0][gwc_pkg::COEF_W-1:0]  weight_c;
	logic [N-1:0][N-1:0][PB-1:0]               cell_in;
	logic [N-1:0][N-1:0][PB-1:0]               cell_out;
	logic [N-1:0][SUM_W-1:0]                   cell_sum;
	gwc_pkg::cell_ctl_t                        ctl;

	logic [TOT_W-1:0]                     total_c;
	logic                                 new_res;
	logic                                 pop;
	logic                                 skid_valid_q;
	logic                                 out_valid_q;
	logic [gwc_pkg::OUT_W-1:0]            out_value_q;
	logic [gwc_pkg::POS_W-1:0]            out_col_q;
	logic [gwc_pkg::POS_W-1:0]            out_row_q;
	logic                                 out_last_q;
	logic [gwc_pkg::OUT_W-1:0]            skid_value_q;
	logic [gwc_pkg::POS_W-1:0]            skid_col_q;
	logic [gwc_pkg::POS_W-1:0]            skid_row_q;
	logic                                 skid_last_q;

	// pipeline moves unless the skid register is occupied
	assign en        = !skid_valid_q;
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !in_stall;
	assign pos_item  = (kind == gwc_pkg::KIND_PIXEL) || (kind == gwc_pkg::KIND_FLUSH);

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gwc_pkg::RADIUS_RST;
		end else if (cfg_wen) begin
			radius_q <= cfg_wdata;
		end
	end

	assign r_eff = (int'(radius_q) > MAX_RADIUS) ? gwc_pkg::RADIUS_W'(MAX_RADIUS) : radius_q;

	// center position of the result for the incoming position
	always_comb begin
		logic signed [SC-1:0] qc_raw;
		logic signed [SC-1:0] tc;
		logic signed [SR-1:0] tr;
		qc_raw = SC'(p_col_q) - SC'(r_eff);
		wrap_c = qc_raw < 0;
		qc     = wrap_c ? (qc_raw + SC'(WIDTH)) : qc_raw;
		qr     = SR'(p_row_q) - SR'(r_eff) - SR'(wrap_c);
		emit_c = pos_item && (qr >= 0) && (qr < HEIGHT);
		last_c = emit_c && (qr == HEIGHT - 1) && (qc == WIDTH - 1);
		for (int k = 0; k < N; k++) begin
			tc = qc + SC'(r_eff) - SC'(k);
			cmask_c[k] = (k <= 2 * int'(r_eff)) && (tc >= 0) && (tc < WIDTH);
			tr = qr + SR'(r_eff) - SR'(k);
			rmask_c[k] = (k <= 2 * int'(r_eff)) && (tr >= 0) && (tr < HEIGHT);
		end
	end

	// stream position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_col_q <= '0;
			p_row_q <= '0;
		end else if (in_accept && pos_item) begin
			if ((pos_item && (qr >= HEIGHT)) || last_c) begin
				p_col_q <= '0;
				p_row_q <= '0;
			end else if (int'(p_col_q) == WIDTH - 1) begin
				p_col_q <= '0;
				p_row_q <= p_row_q + RW'(1);
			end else begin
				p_col_q <= p_col_q + CW'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_meta    <= '0;
		end else if (en) begin
			s1_valid_q   <= in_accept && (pos_item || (kind == gwc_pkg::KIND_COEF));
			s1_meta.emit <= in_accept && emit_c;
			s1_meta.last <= last_c;
			s1_meta.col  <= gwc_pkg::POS_W'(qc);
			s1_meta.row  <= gwc_pkg::POS_W'(qr);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_pos   <= pos_item;
			s1_coef  <= (kind == gwc_pkg::KIND_COEF);
			s1_px    <= (kind == gwc_pkg::KIND_PIXEL) ? PB'(pixel_value) : '0;
			s1_col   <= p_col_q;
			s1_cmask <= cmask_c;
			s1_rmask <= rmask_c;
			s1_ccol  <= coef_col;
			s1_crow  <= coef_row;
			s1_cval  <= coef_value;
		end
	end

	// line buffer: each word holds the last N-1 rows of one column
	assign lb_we    = en && s1_valid_q && s1_pos;
	assign lb_wdata = {lb_rdata[LB_W-PB-1:0], s1_px};

	gwc_ram #(
		.DW    (LB_W),
		.DEPTH (WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (lb_we),
		.waddr (s1_col),
		.wdata (lb_wdata),
		.re    (in_accept && pos_item),
		.raddr (p_col_q),
		.rdata (lb_rdata)
	);

	// weight table, updated in stream order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (en && s1_valid_q && s1_coef && (int'(s1_ccol) <= MAX_RADIUS)
		             && (int'(s1_crow) <= MAX_RADIUS)) begin
			coef_q[CI_W'(int'(s1_crow) * SIDE + int'(s1_ccol))] <= s1_cval;
		end
	end

	// weight per window element from absolute offsets
	always_comb begin
		int ar;
		int ac;
		for (int k = 0; k < N; k++) begin
			for (int j = 0; j < N; j++) begin
				ar = (int'(r_eff) > j) ? (int'(r_eff) - j) : (j - int'(r_eff));
				ac = (int'(r_eff) > k) ? (int'(r_eff) - k) : (k - int'(r_eff));
				if ((ar < SIDE) && (ac < SIDE)) begin
					weight_c[k][j] = coef_q[CI_W'(ar * SIDE + ac)];
				end else begin
					weight_c[k][j] = '0;
				end
			end
		end
	end

	assign ctl.en    = en;
	assign ctl.shift = en && s1_valid_q && s1_pos;

	// chain of column cells, newest column in cell 0
	always_comb begin
		cell_in[0][0] = s1_px;
		for (int j = 1; j < N; j++) begin
			cell_in[0][j] = lb_rdata[(j-1)*PB +: PB];
		end
		for (int k = 1; k < N; k++) begin
			cell_in[k] = cell_out[k-1];
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		gwc_cell #(
			.N  (N),
			.PB (PB)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.col_in  (cell_in[k]),
			.mask    (s1_rmask & {N{s1_cmask[k]}}),
			.weight  (weight_c[k]),
			.col_out (cell_out[k]),
			.sum_out (cell_sum[k])
		);
	end

	// result tags follow the product and column-sum stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else if (en) begin
			meta_s2 <= s1_meta;
			meta_s3 <= meta_s2;
		end
	end

	// sum over cells
	always_comb begin
		total_c = '0;
		for (int k = 0; k < N; k++) begin
			total_c = total_c + TOT_W'(cell_sum[k]);
		end
	end

	assign new_res = en && meta_s3.emit;
	assign pop     = out_valid_q && !out_stall;

	// output register and skid register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (new_res) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (new_res) begin
			if (out_valid_q && !pop) begin
				skid_value_q <= gwc_pkg::OUT_W'(total_c);
				skid_col_q   <= meta_s3.col;
				skid_row_q   <= meta_s3.row;
				skid_last_q  <= meta_s3.last;
			end else begin
				out_value_q <= gwc_pkg::OUT_W'(total_c);
				out_col_q   <= meta_s3.col;
				out_row_q   <= meta_s3.row;
				out_last_q  <= meta_s3.last;
			end
		end else if (pop && skid_valid_q) begin
			out_value_q <= skid_value_q;
			out_col_q   <= skid_col_q;
			out_row_q   <= skid_row_q;
			out_last_q  <= skid_last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_col    = out_col_q;
	assign out_row    = out_row_q;
	assign frame_last = out_last_q;

	// skid only holds a transaction behind a waiting one
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid register filled without output stall");

	// column counter stays inside the line
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(p_col_q) < WIDTH)
		else $error("column counter out of range");

endmodule
